// File: rtl/core/assert_macros.svh
// assertion macros used by the handle timer slot table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define HTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hts_pkg.sv
// types and constants of the handle timer slot table
package hts_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int HANDLE_W    = 31;
  localparam int TIME_W      = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 72;
  // remainder unit: reciprocal of up to 33 bits times a 31-bit handle
  localparam int MOD_MAGIC_W = HANDLE_W + 2;
  localparam int MOD_PROD_W  = HANDLE_W + MOD_MAGIC_W;

  localparam int QRY_ELAPSED = 0;
  localparam int QRY_LEFT    = 1;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_ELAPSED = 2'd2,
    OP_LEFT    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_READ,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   duration;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

endpackage

// File: rtl/core/hts_ram.sv
// generic single-port ram with registered read
module hts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hts_mod.sv
// handle modulo slot count by reciprocal multiplication
module hts_mod #(
  parameter int SLOTS = hts_pkg::SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [hts_pkg::HANDLE_W-1:0]           value,
  output logic                                   done,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rem
);
  import hts_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // floor(v / SLOTS) equals (v * MAGIC) >> SHIFT for every 31-bit v
  localparam int                     SHIFT   = HANDLE_W + IDX_W;
  localparam logic [63:0]            POW     = 64'd1 << SHIFT;
  localparam logic [63:0]            MAGIC64 = (POW + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [MOD_MAGIC_W-1:0] MAGIC   = MAGIC64[MOD_MAGIC_W-1:0];

  logic                  s1_r, s1_nxt;
  logic                  s2_r, s2_nxt;
  logic                  done_r, done_nxt;
  logic [HANDLE_W-1:0]   val_r, val_nxt;
  logic [MOD_PROD_W-1:0] prod_r, prod_nxt;
  logic [IDX_W-1:0]      rem_r, rem_nxt;
  logic [MOD_PROD_W-1:0] quot_full;
  logic [HANDLE_W-1:0]   quot;
  logic [HANDLE_W-1:0]   back;
  logic [HANDLE_W-1:0]   resid;

  always_comb begin
    quot_full = prod_r >> SHIFT;
    quot      = quot_full[HANDLE_W-1:0];
    // quotient times SLOTS never exceeds the handle, so 31 bits hold it
    back      = quot * HANDLE_W'(SLOTS);
    resid     = val_r - back;
    s1_nxt    = start;
    s2_nxt    = s1_r;
    done_nxt  = s2_r;
    val_nxt   = start ? value : val_r;
    prod_nxt  = s1_r ? ({{(MOD_PROD_W-HANDLE_W){1'b0}}, val_r} *
                        {{(MOD_PROD_W-MOD_MAGIC_W){1'b0}}, MAGIC}) : prod_r;
    rem_nxt   = s2_r ? resid[IDX_W-1:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/handle_timer_slot_table.sv
// Timer table of SLOTS entries found by generational handles (slot = handle mod SLOTS).
// One request at a time; the result sits in an output register so the next request
// may be taken while it waits. A start walks the candidate handles one per cycle over
// the per-slot busy flags and writes the claimed entry into the slot ram, or reports a
// full table. A stop or time query maps the handle to a slot in the remainder unit by
// a reciprocal multiply, then one ram read, the clamp for queries and, for time-left
// queries, the final subtract. Stops and queries with a negative or zero handle go
// straight to the result. A result still in the output register stalls the next one
// in its last cycle. The busy flags clear at reset, so no ram clearing pass is needed.
module handle_timer_slot_table #(
  parameter int SLOTS = hts_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // handle[31:0], duration_us[63:32], now_us[95:64]
  input  logic [hts_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[1:0]
  input  logic [hts_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], handle_out[32:2], time_value[64:33], zero[71:65]
  output logic [hts_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import hts_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;
  logic [TIME_W-1:0]   dur_r, dur_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [HANDLE_W-1:0] cand_r, cand_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [HANDLE_W-1:0] next_handle_r, next_handle_nxt;
  logic [IDX_W-1:0]    next_idx_r, next_idx_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]   sdur_r, sdur_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] res_hout_r, res_hout_nxt;
  logic [TIME_W-1:0]   res_tval_r, res_tval_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_hout_r, out_hout_nxt;
  logic [TIME_W-1:0]   out_tval_r, out_tval_nxt;

  logic                in_acc;
  logic [HANDLE_W-1:0] cand_succ;
  logic [IDX_W-1:0]    idx_succ;
  logic [TIME_W-1:0]   diff;
  logic                mod_start;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  slot_t               ram_wdata;
  slot_t               ram_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // counter wraps back to SLOTS so a free mark of zero is never handed out
  assign cand_succ = (cand_r == {HANDLE_W{1'b1}}) ? HANDLE_W'(SLOTS) : cand_r + 1'b1;
  assign idx_succ  = ((cand_r == {HANDLE_W{1'b1}}) || (idx_r == IDX_W'(SLOTS-1))) ?
                     '0 : idx_r + 1'b1;
  assign diff      = now_r - ram_rdata.start_time;

  assign ram_wdata = '{start_time: now_r, duration: dur_r, handle: cand_r};
  assign ram_addr  = (state_r == ST_SCAN) ? idx_r : mod_rem;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    h_nxt           = h_r;
    dur_nxt         = dur_r;
    now_nxt         = now_r;
    cand_nxt        = cand_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    next_handle_nxt = next_handle_r;
    next_idx_nxt    = next_idx_r;
    valid_nxt       = valid_r;
    elapsed_nxt     = elapsed_r;
    sdur_nxt        = sdur_r;
    res_status_nxt  = res_status_r;
    res_hout_nxt    = res_hout_r;
    res_tval_nxt    = res_tval_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_hout_nxt    = out_hout_r;
    out_tval_nxt    = out_tval_r;
    mod_start       = 1'b0;
    ram_we          = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = op_t'(in_tuser);
          h_nxt          = in_tdata[HANDLE_W-1:0];
          dur_nxt        = in_tdata[63:32];
          now_nxt        = in_tdata[95:64];
          cand_nxt       = next_handle_r;
          idx_nxt        = next_idx_r;
          cnt_nxt        = '0;
          res_status_nxt = STAT_NOT_FOUND;
          res_hout_nxt   = '0;
          res_tval_nxt   = '0;
          if (op_t'(in_tuser) == OP_START) begin
            state_nxt = ST_SCAN;
          end else if (in_tdata[31] || (in_tdata[HANDLE_W-1:0] == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = ST_MOD;
          end
        end
      end
      ST_SCAN: begin
        if (!valid_r[idx_r]) begin
          ram_we           = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          next_handle_nxt  = cand_succ;
          next_idx_nxt     = idx_succ;
          res_status_nxt   = STAT_OK;
          res_hout_nxt     = cand_r;
          state_nxt        = ST_DONE;
        end else if (cnt_r == IDX_W'(SLOTS-1)) begin
          res_status_nxt = STAT_FULL;
          state_nxt      = ST_DONE;
        end else begin
          cand_nxt = cand_succ;
          idx_nxt  = idx_succ;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ST_MOD: begin
        // ram read is issued at mod_rem in this cycle
        if (mod_done) begin
          idx_nxt   = mod_rem;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (!valid_r[idx_r] || (ram_rdata.handle != h_r)) begin
          state_nxt = ST_DONE;
        end else if (op_r == OP_STOP) begin
          valid_nxt[idx_r] = 1'b0;
          res_status_nxt   = STAT_OK;
          state_nxt        = ST_DONE;
        end else begin
          elapsed_nxt = (diff > ram_rdata.duration) ? ram_rdata.duration : diff;
          sdur_nxt    = ram_rdata.duration;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        res_status_nxt = STAT_OK;
        if (op_r == OP_LEFT) begin
          res_tval_nxt = sdur_r - elapsed_r;
        end else begin
          res_tval_nxt = elapsed_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hout_nxt   = res_hout_r;
          out_tval_nxt   = res_tval_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      next_handle_r <= HANDLE_W'(SLOTS);
      next_idx_r    <= '0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_handle_r <= next_handle_nxt;
      next_idx_r    <= next_idx_nxt;
      valid_r       <= valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    h_r          <= h_nxt;
    dur_r        <= dur_nxt;
    now_r        <= now_nxt;
    cand_r       <= cand_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    elapsed_r    <= elapsed_nxt;
    sdur_r       <= sdur_nxt;
    res_status_r <= res_status_nxt;
    res_hout_r   <= res_hout_nxt;
    res_tval_r   <= res_tval_nxt;
    out_status_r <= out_status_nxt;
    out_hout_r   <= out_hout_nxt;
    out_tval_r   <= out_tval_nxt;
  end

  hts_mod #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_tdata[HANDLE_W-1:0]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  hts_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - HANDLE_W - TIME_W){1'b0}},
                       out_tval_r, out_hout_r, out_status_r};

  `HTS_ASSERT(a_next_handle_nonzero, next_handle_r != '0, "next handle is zero")
  `HTS_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result not from done")
  `HTS_ASSERT_NXT(a_claim_sets_busy, (state_r == ST_SCAN) && !valid_r[idx_r], valid_r[$past(idx_r)], "claimed slot not busy")
  `HTS_ASSERT_IMP(a_fail_zero_payload, out_valid_r && (out_status_r != STAT_OK), (out_hout_r == '0) && (out_tval_r == '0), "failed request with payload")

endmodule

// File: tb/tb_handle_timer_slot_table.sv
// testbench for the handle timer slot table: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_handle_timer_slot_table;
  import hts_pkg::*;

  localparam int NSLOTS      = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    op_t         op;
    logic [31:0] handle;
    logic [31:0] dur;
    logic [31:0] now;
  } timer_cmd_t;

  typedef struct {
    status_t     st;
    logic [30:0] handle;
    logic [31:0] tval;
  } timer_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  handle_timer_slot_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the timer table
  logic [30:0] tbl_handle [NSLOTS];
  logic [31:0] tbl_dur    [NSLOTS];
  logic [31:0] tbl_start  [NSLOTS];
  logic [30:0] tbl_next;

  timer_cmd_t   cmd_q[$];
  timer_reply_t reply_q[$];
  timer_cmd_t   drive_cmd;
  logic [31:0]  retired_q[$];

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int reply_cnt    = 0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int in_idle_pct  = 26;
  int out_idle_pct = 88;
  logic [31:0] clock_us = 32'd0;

  function automatic logic [30:0] handle_succ(logic [30:0] h);
    if (h == 31'h7FFF_FFFF) return 31'(NSLOTS);
    return h + 31'd1;
  endfunction

  // apply one accepted request to the shadow table and queue its reply
  task automatic timer_table_apply(input timer_cmd_t c);
    timer_reply_t r;
    logic [30:0] cand;
    logic [31:0] e;
    int idx;
    r.st = STAT_NOT_FOUND;
    r.handle = '0;
    r.tval = '0;
    if (c.op == OP_START) begin
      r.st = STAT_FULL;
      cand = tbl_next;
      for (int i = 0; i < NSLOTS; i++) begin
        idx = int'(cand % NSLOTS);
        if (cand != 0 && tbl_handle[idx] == 0) begin
          tbl_handle[idx] = cand;
          tbl_dur[idx] = c.dur;
          tbl_start[idx] = c.now;
          r.handle = cand;
          r.st = STAT_OK;
          tbl_next = handle_succ(cand);
          break;
        end
        cand = handle_succ(cand);
      end
    end else if (c.handle != 0 && !c.handle[31]) begin
      idx = int'(c.handle % NSLOTS);
      if (tbl_handle[idx] == c.handle[30:0]) begin
        r.st = STAT_OK;
        if (c.op == OP_STOP) begin
          tbl_handle[idx] = '0;
          tbl_dur[idx] = '0;
          tbl_start[idx] = '0;
        end else begin
          e = c.now - tbl_start[idx];
          if (e > tbl_dur[idx]) e = tbl_dur[idx];
          if (int'(c.op) - 2 == QRY_LEFT) e = tbl_dur[idx] - e;
          r.tval = e;
        end
      end
    end
    reply_q.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch in reply %0d, %s: got %h, want %h", reply_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // driver: one request held on the input channel until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        timer_table_apply(drive_cmd);
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          drive_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {drive_cmd.now, drive_cmd.dur, drive_cmd.handle};
          in_tuser <= drive_cmd.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each reply with the oldest prediction
  always @(posedge clk) begin
    timer_reply_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("unexpected reply", out_tdata[31:0], '0);
        end else begin
          w = reply_q.pop_front();
          if (out_tdata[1:0] !== w.st) flag_mismatch("status", out_tdata[1:0], w.st);
          if (out_tdata[32:2] !== w.handle)
            flag_mismatch("handle_out", out_tdata[32:2], w.handle);
          if (out_tdata[64:33] !== w.tval)
            flag_mismatch("time_value", out_tdata[64:33], w.tval);
          if (out_tdata[71:65] !== '0) flag_mismatch("pad bits", out_tdata[71:65], '0);
        end
        reply_cnt++;
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_handle_timer_slot_table NOT OK");
      $finish;
    end
  end

  // requests are made one at a time, so the shadow table is current when the next is chosen
  task automatic push_cmd(input op_t op, input logic [31:0] handle, input logic [31:0] dur,
                          input logic [31:0] now);
    timer_cmd_t c;
    while (queued_cnt != accepted_cnt) @(negedge clk);
    c.op = op;
    c.handle = handle;
    c.dur = dur;
    c.now = now;
    cmd_q.push_back(c);
    queued_cnt++;
  endtask

  task automatic drain_replies();
    while (queued_cnt != accepted_cnt || reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic gen_random_cmd(input int start_pct);
    logic [31:0] live[$];
    logic [31:0] h, d, n;
    int r;
    op_t op;
    while (queued_cnt != accepted_cnt) @(negedge clk);
    for (int i = 0; i < NSLOTS; i++)
      if (tbl_handle[i] != 0) live.push_back({1'b0, tbl_handle[i]});
    r = $urandom_range(99);
    if (r < start_pct) op = OP_START;
    else op = op_t'($urandom_range(1, 3));
    // handle: mostly live timers, the rest stale, aliased, negative, zero or noise
    r = $urandom_range(99);
    h = $urandom;
    if (r < 70 && live.size() > 0) begin
      h = live[$urandom_range(live.size() - 1)];
    end else if (r < 80 && retired_q.size() > 0) begin
      h = retired_q[$urandom_range(retired_q.size() - 1)];
    end else if (r < 85 && live.size() > 0) begin
      h = live[$urandom_range(live.size() - 1)] + NSLOTS * $urandom_range(1, 4);
    end else if (r < 90) begin
      h = {1'b1, 31'($urandom)};
    end else if (r < 94) begin
      h = '0;
    end
    if (op == OP_STOP && h != 0 && !h[31] && tbl_handle[h % NSLOTS] == h[30:0]) begin
      retired_q.push_back(h);
      if (retired_q.size() > 32) void'(retired_q.pop_front());
    end
    r = $urandom_range(99);
    if (r < 40) d = $urandom_range(0, 400);
    else if (r < 65) d = $urandom_range(0, 5000);
    else if (r < 85) d = $urandom;
    else if (r < 92) d = '0;
    else d = 32'hFFFF_FFFF;
    r = $urandom_range(99);
    if (r < 3) clock_us = $urandom;
    else if (r < 5) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 600);
    else clock_us = clock_us + $urandom_range(0, 300);
    n = ($urandom_range(99) < 5) ? $urandom : clock_us;
    push_cmd(op, h, d, n);
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_handle[i] = '0;
      tbl_dur[i] = '0;
      tbl_start[i] = '0;
    end
    tbl_next = 31'(NSLOTS);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, zero duration, time wrap, clamping, bad handles, full table
    push_cmd(OP_STOP, 32'd16, 32'd0, 32'd0);
    push_cmd(OP_ELAPSED, 32'd0, 32'd0, 32'd0);
    push_cmd(OP_START, 32'hFFFF_FFFF, 32'd0, 32'd0);
    push_cmd(OP_ELAPSED, 32'd16, 32'd0, 32'd5);
    push_cmd(OP_START, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    push_cmd(OP_ELAPSED, 32'd17, 32'd0, 32'h0000_0010);
    push_cmd(OP_LEFT, 32'd17, 32'hFFFF_FFFF, 32'h0000_0010);
    push_cmd(OP_START, 32'h5555_5555, 32'd100, 32'd1000);
    push_cmd(OP_ELAPSED, 32'd18, 32'd0, 32'd1050);
    push_cmd(OP_LEFT, 32'd18, 32'd0, 32'd1050);
    push_cmd(OP_LEFT, 32'd18, 32'd0, 32'd5000);
    push_cmd(OP_ELAPSED, 32'd18, 32'd0, 32'd999);
    push_cmd(OP_STOP, 32'h8000_0000, 32'd0, 32'd0);
    push_cmd(OP_LEFT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(OP_LEFT, 32'd34, 32'd0, 32'd1100);
    push_cmd(OP_STOP, 32'd18, 32'd0, 32'd1200);
    push_cmd(OP_ELAPSED, 32'd18, 32'd0, 32'd1300);
    repeat (14) push_cmd(OP_START, $urandom, $urandom_range(0, 3000), 32'd2000);
    push_cmd(OP_START, 32'd0, 32'd77, 32'd2100);
    clock_us = 32'd2100;

    for (int i = 0; i < 600; i++) begin
      gen_random_cmd(((i / 80) % 2 == 0) ? 20 : 60);
      if (i == 300) drain_replies();
    end
    drain_replies();
    in_idle_pct = 88;
    out_idle_pct = 26;
    for (int i = 0; i < 600; i++) gen_random_cmd(((i / 80) % 2 == 0) ? 60 : 20);
    drain_replies();
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 400; i++) gen_random_cmd(((i / 60) % 2 == 0) ? 20 : 60);
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("tb_handle_timer_slot_table OK");
    end else begin
      $display("tb_handle_timer_slot_table NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/hts_pkg.sv
rtl/core/hts_ram.sv
rtl/core/hts_mod.sv
rtl/core/handle_timer_slot_table.sv
tb/tb_handle_timer_slot_table.sv
